// ===== rtl/ldpf_pkg.sv =====
// ============================================================================
// ldpf_pkg: shared types and constants of the local dispersion peak filter
// Transaction types for both channels, the control bundle that drives the
// sample cells, and the constants of the divide-by-three reciprocal.
// ============================================================================
package ldpf_pkg;

  localparam int SAMPLE_W      = 8;
  localparam int DISP_W        = 9;
  localparam int REACH_DEFAULT = 8;

  // floor(s / 3) == (s * 683) >> 11 for every s up to 765
  localparam int             RECIP_W     = 10;
  localparam logic [RECIP_W-1:0] RECIP3  = 10'd683;
  localparam int             RECIP_SHIFT = 11;

  // Sum widths: three bytes and six bytes
  localparam int SUM3_W = SAMPLE_W + 2;
  localparam int SUM6_W = SAMPLE_W + 3;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                end_of_signal;
  } ldpf_in_t;

  typedef struct packed {
    logic signed [DISP_W-1:0] dispersion;
    logic                     last_result;
  } ldpf_out_t;

  // Per-cycle control shared by every cell of the chain
  typedef struct packed {
    logic step;     // chain moves this cycle
    logic accept;   // the move takes a new input sample
    logic end_in;   // that sample closes the sequence
  } ldpf_step_t;

endpackage

// ===== rtl/local_dispersion_peak_filter_top.sv =====
// ============================================================================
// local_dispersion_peak_filter_top: streaming local dispersion filter
// Byte samples in, one signed center-minus-surround mean per sample out.
// ============================================================================
// Usage:
//   item (valid/ready) carries one sample and an end_of_signal flag; result
//   (valid/ready) carries the 9-bit signed dispersion and last_result.
//   Sample p of a sequence gets its result once sample p+REACH has been
//   taken; from there it moves through the sum stage into the result register.
//   Ends are handled by mirror reflection with the edge sample repeated.
// Throughput:
//   One sample per cycle unless result_ready stalls the pipeline. After
//   the end_of_signal sample the chain takes REACH flush steps fed from the
//   mirror stack, item_ready is low during them, and they deliver the
//   pending results, the last one flagged; n samples use n + REACH chain steps.
// Reset:
//   rst clears the pipeline valid bits, the sample count and the flush count;
//   the history bytes need no clearing, every read byte is rewritten first.
// Stalls:
//   A three-deep pipeline (history chain, sum stage, output register) holds
//   its results while result_ready is low; outside a flush, item_ready drops
//   only once every stage is full.
// ============================================================================
module local_dispersion_peak_filter_top
  import ldpf_pkg::*;
#(
  parameter int REACH = REACH_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_ready,
  input  ldpf_in_t  item,
  output logic      result_valid,
  input  logic      result_ready,
  output ldpf_out_t result
);

  localparam int DEPTH = 2 * REACH + 1;
  localparam int CW    = $clog2(REACH + 1);

  logic [SAMPLE_W-1:0] hist      [DEPTH];
  logic [SAMPLE_W-1:0] hist_next [DEPTH];
  logic [SAMPLE_W-1:0] mirror    [REACH];

  logic [CW-1:0]       count;
  logic [CW-1:0]       flush_cnt;
  logic                flushing;
  logic                win_valid;
  logic                win_last;
  logic                take;
  logic                adv_chain;
  logic                in_acc;
  logic                flush_step;
  logic                flush_done;
  logic                emit;
  logic [SAMPLE_W-1:0] inject;
  ldpf_step_t          ctl;

  // Chain control
  assign flushing   = flush_cnt != '0;
  assign adv_chain  = !win_valid || take;
  assign item_ready = adv_chain && !flushing;
  assign in_acc     = item_valid && item_ready;
  assign flush_step = flushing && adv_chain;
  assign flush_done = flush_step && (flush_cnt == CW'(1));
  assign emit       = ctl.step && (count == CW'(REACH));
  assign inject     = in_acc ? item.sample : mirror[0];

  assign ctl.step   = in_acc || flush_step;
  assign ctl.accept = in_acc;
  assign ctl.end_in = item.end_of_signal;

  // Sample count, saturating at REACH; cleared when the flush completes
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (flush_done) begin
      count <= '0;
    end else if (ctl.step && count != CW'(REACH)) begin
      count <= count + CW'(1);
    end
  end

  // Flush counter: REACH steps after the closing sample
  always_ff @(posedge clk) begin
    if (rst) begin
      flush_cnt <= '0;
    end else if (in_acc && item.end_of_signal) begin
      flush_cnt <= CW'(REACH);
    end else if (flush_step) begin
      flush_cnt <= flush_cnt - CW'(1);
    end
  end

  // Window valid flag of the history chain stage
  always_ff @(posedge clk) begin
    if (rst) begin
      win_valid <= 1'b0;
    end else if (ctl.step) begin
      win_valid <= emit;
    end else if (take) begin
      win_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.step) begin
      win_last <= flush_done;
    end
  end

  // History chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_tap
    if (i == 0) begin : g_head
      ldpf_tap_cell #(
        .INDEX (i),
        .REACH (REACH)
      ) u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .count      (count),
        .sample     (item.sample),
        .shift_in   (inject),
        .value      (hist[i]),
        .value_next (hist_next[i])
      );
    end else begin : g_body
      ldpf_tap_cell #(
        .INDEX (i),
        .REACH (REACH)
      ) u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .count      (count),
        .sample     (item.sample),
        .shift_in   (hist[i-1]),
        .value      (hist[i]),
        .value_next (hist_next[i])
      );
    end
  end

  // Mirror stack over the head of the chain
  for (genvar i = 0; i < REACH; i++) begin : g_mirror
    if (i == REACH - 1) begin : g_top
      ldpf_mirror_cell u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .hist_next  (hist_next[i]),
        .from_above (mirror[i]),
        .value      (mirror[i])
      );
    end else begin : g_body
      ldpf_mirror_cell u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .hist_next  (hist_next[i]),
        .from_above (mirror[i+1]),
        .value      (mirror[i])
      );
    end
  end

  // Window arithmetic and output register
  ldpf_window u_window (
    .clk          (clk),
    .rst          (rst),
    .win_valid    (win_valid),
    .win_last     (win_last),
    .near_taps    ({hist[2], hist[1], hist[0]}),
    .center_taps  ({hist[REACH+1], hist[REACH], hist[REACH-1]}),
    .far_taps     ({hist[2*REACH], hist[2*REACH-1], hist[2*REACH-2]}),
    .take         (take),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  // Checks
  a_flush_load: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready && item.end_of_signal) |=> (flush_cnt == CW'(REACH)))
    else $error("flush count not loaded after closing sample");

  a_no_take_in_flush: assert property (@(posedge clk) disable iff (rst)
    (flush_cnt != '0) |-> !item_ready)
    else $error("sample taken during flush");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(REACH))
    else $error("sample count beyond reach");

endmodule

// ===== rtl/ldpf_tap_cell.sv =====
// ============================================================================
// ldpf_tap_cell: one byte of the sample history chain
// Takes its neighbor's byte on every step. Cells at mirrored positions left of
// the sequence start take the incoming sample instead, so that the chain
// always shows the reflected signal.
// ============================================================================
module ldpf_tap_cell
  import ldpf_pkg::*;
#(
  parameter int INDEX = 0,
  parameter int REACH = REACH_DEFAULT
) (
  input  logic                            clk,
  input  ldpf_step_t                      ctl,
  input  logic [$clog2(REACH+1)-1:0]      count,
  input  logic [SAMPLE_W-1:0]             sample,
  input  logic [SAMPLE_W-1:0]             shift_in,
  output logic [SAMPLE_W-1:0]             value,
  output logic [SAMPLE_W-1:0]             value_next
);

  localparam int CW   = $clog2(REACH + 1);
  localparam bit ODD  = (INDEX % 2) == 1;
  localparam bit DEEP = INDEX > 0;
  localparam int HALF = DEEP ? (INDEX - 1) / 2 : 0;
  localparam int LOW  = (INDEX > REACH) ? INDEX - REACH : 0;

  logic odd_load;
  logic fill_load;

  // Sample k also lands at mirrored position -(k+1)
  assign odd_load = ctl.accept && ODD && (count == CW'(HALF));

  // A short sequence ends: the far mirrored positions repeat the end sample
  assign fill_load = ctl.accept && ctl.end_in && DEEP &&
                     (count <= CW'(HALF)) && (count >= CW'(LOW));

  always_comb begin
    if (!ctl.step) begin
      value_next = value;
    end else if (odd_load || fill_load) begin
      value_next = sample;
    end else begin
      value_next = shift_in;
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

// ===== rtl/ldpf_mirror_cell.sv =====
// ============================================================================
// ldpf_mirror_cell: one byte of the end-of-sequence mirror stack
// Tracks the head of the history chain while samples arrive, then shifts
// toward the head during a flush so the chain is fed the reflected tail.
// ============================================================================
module ldpf_mirror_cell
  import ldpf_pkg::*;
(
  input  logic                clk,
  input  ldpf_step_t          ctl,
  input  logic [SAMPLE_W-1:0] hist_next,
  input  logic [SAMPLE_W-1:0] from_above,
  output logic [SAMPLE_W-1:0] value
);

  always_ff @(posedge clk) begin
    if (ctl.step) begin
      value <= ctl.accept ? hist_next : from_above;
    end
  end

endmodule

// ===== rtl/ldpf_window.sv =====
// ============================================================================
// ldpf_window: window arithmetic and output register
// Stage one adds the three center taps and the six surrounding taps; stage
// two divides both by reciprocal multiplication and takes the difference.
// ============================================================================
module ldpf_window
  import ldpf_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        win_valid,
  input  logic                        win_last,
  input  logic [2:0][SAMPLE_W-1:0]    near_taps,
  input  logic [2:0][SAMPLE_W-1:0]    center_taps,
  input  logic [2:0][SAMPLE_W-1:0]    far_taps,
  output logic                        take,
  output logic                        result_valid,
  input  logic                        result_ready,
  output ldpf_out_t                   result
);

  localparam int PROD_W = SUM3_W + RECIP_W;

  logic              sum_valid;
  logic              sum_last;
  logic [SUM3_W-1:0] sum3;
  logic [SUM6_W-1:0] sum6;
  logic              adv_out;
  logic [PROD_W-1:0] prod3;
  logic [PROD_W-1:0] prod6;
  logic [SAMPLE_W-1:0] mean3;
  logic [SAMPLE_W-1:0] mean6;

  assign adv_out = !result_valid || result_ready;
  assign take    = !sum_valid || adv_out;

  // Stage one: window sums
  always_ff @(posedge clk) begin
    if (rst) begin
      sum_valid <= 1'b0;
    end else if (take) begin
      sum_valid <= win_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take && win_valid) begin
      sum_last <= win_last;
      sum3 <= SUM3_W'(center_taps[0]) + SUM3_W'(center_taps[1]) +
              SUM3_W'(center_taps[2]);
      sum6 <= SUM6_W'(near_taps[0]) + SUM6_W'(near_taps[1]) +
              SUM6_W'(near_taps[2]) + SUM6_W'(far_taps[0]) +
              SUM6_W'(far_taps[1]) + SUM6_W'(far_taps[2]);
    end
  end

  // Stage two: divide by 3 and by 6 (halve, then divide by 3)
  assign prod3 = PROD_W'(sum3) * PROD_W'(RECIP3);
  assign prod6 = PROD_W'(sum6[SUM6_W-1:1]) * PROD_W'(RECIP3);
  assign mean3 = prod3[RECIP_SHIFT +: SAMPLE_W];
  assign mean6 = prod6[RECIP_SHIFT +: SAMPLE_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv_out) begin
      result_valid <= sum_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_out && sum_valid) begin
      result.dispersion  <= $signed({1'b0, mean3}) - $signed({1'b0, mean6});
      result.last_result <= sum_last;
    end
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb_top: self-checking bench for local_dispersion_peak_filter_top
// Byte sequences, each closed by an end_of_signal sample, are pushed through
// the item channel. A behavioral copy of the filter computes the dispersion
// of every sample, and each result transaction is matched in order against
// it. A short table of hand-picked sequences runs first. Random sequences of
// mixed length follow, under three idle patterns on the two channels.
// ============================================================================
module tb_top
  import ldpf_pkg::*;
();

  localparam int REACH     = REACH_DEFAULT;
  localparam int HIST_LEN  = 2 * REACH + 1;
  localparam int IDX_W     = $clog2(HIST_LEN);
  localparam int RAND_ITEMS = 250;
  localparam int CYCLE_LIMIT = 200000;

  logic      clk = 1'b0;
  logic      rst;
  logic      item_valid;
  logic      item_ready;
  ldpf_in_t  item;
  logic      result_valid;
  logic      result_ready;
  ldpf_out_t result;

  local_dispersion_peak_filter_top #(.REACH(REACH)) DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Filter state of the behavioral copy: newest sample at index 0
  logic [SAMPLE_W-1:0] tap_line [HIST_LEN];
  int                  taps_taken;

  ldpf_out_t step_results [$];   // results caused by the last sample
  ldpf_out_t pending_results [$]; // results still owed by the block
  ldpf_out_t want;

  int errors = 0;
  int cycles = 0;
  int tx_idle_pct;
  int rx_idle_pct;

  // Directed table row; fixed_disp applies when has_fixed is set
  typedef struct {
    logic [SAMPLE_W-1:0] smp;
    bit                  eos;
    bit                  has_fixed;
    int                  fixed_disp;
  } stim_row_t;

  stim_row_t stim_rows [$];

  // Sample at offset d from the newest one, mirrored at both ends
  function automatic int tap_at(int d, bit fin);
    int t;
    t = taps_taken - 1;
    if (fin && d > 0) d = 1 - d;
    if (t + d < 0) d = -(t + d) - 1 - t;
    if (d > 0) d = 0;
    if (t + d < 0) d = -t;
    if (d < -(HIST_LEN - 1)) d = -(HIST_LEN - 1);
    return int'(tap_line[IDX_W'(-d)]);
  endfunction

  // Three-sample mean around c minus the six-sample mean at distance 6..8
  function automatic logic signed [DISP_W-1:0] mean_gap(int c, bit fin);
    int center;
    int around;
    int diff;
    center = (tap_at(c - 1, fin) + tap_at(c, fin) + tap_at(c + 1, fin)) / 3;
    around = (tap_at(c - REACH, fin) + tap_at(c - REACH + 1, fin) +
              tap_at(c - REACH + 2, fin) + tap_at(c + REACH - 2, fin) +
              tap_at(c + REACH - 1, fin) + tap_at(c + REACH, fin)) / 6;
    diff = center - around;
    return diff[DISP_W-1:0];
  endfunction

  // Advance the behavioral filter by one sample, fill step_results
  task automatic run_filter(input ldpf_in_t it);
    int        t;
    int        m;
    ldpf_out_t r;
    step_results.delete();
    for (int i = HIST_LEN - 1; i > 0; i--)
      tap_line[IDX_W'(i)] = tap_line[IDX_W'(i - 1)];
    tap_line[0] = it.sample;
    if (taps_taken < HIST_LEN) taps_taken++;
    t = taps_taken - 1;
    if (!it.end_of_signal) begin
      if (taps_taken > REACH) begin
        r.dispersion  = mean_gap(-REACH, 1'b0);
        r.last_result = 1'b0;
        step_results.push_back(r);
      end
    end else begin
      // flush every unanswered sample, oldest first
      m = (t < REACH) ? t : REACH;
      for (int c = -m; c <= 0; c++) begin
        r.dispersion  = mean_gap(c, 1'b1);
        r.last_result = (c == 0);
        step_results.push_back(r);
      end
      taps_taken = 0;
    end
  endtask

  // Drive one transaction, record what it should produce once accepted
  task automatic send_sample(input logic [SAMPLE_W-1:0] smp, input bit eos,
                             input bit has_fixed, input int fixed_disp);
    ldpf_in_t it;
    it.sample        = smp;
    it.end_of_signal = eos;
    while ($urandom_range(99) < tx_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    do @(posedge clk); while (!item_ready);
    run_filter(it);
    foreach (step_results[i]) begin
      if (has_fixed) step_results[i].dispersion = DISP_W'(fixed_disp);
      pending_results.push_back(step_results[i]);
    end
  endtask

  task automatic add_row(input logic [SAMPLE_W-1:0] smp, input bit eos,
                         input bit has_fixed, input int fixed_disp);
    stim_row_t row;
    row.smp        = smp;
    row.eos        = eos;
    row.has_fixed  = has_fixed;
    row.fixed_disp = fixed_disp;
    stim_rows.push_back(row);
  endtask

  // Receiver side: random back-pressure per phase
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      result_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Result check against the oldest outstanding expectation
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result transaction, actual disp %0d last %0b",
                 $time, result.dispersion, result.last_result);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (result.dispersion !== want.dispersion) begin
          $display("%0t: dispersion mismatch, expected %0d actual %0d",
                   $time, want.dispersion, result.dispersion);
          errors++;
        end
        if (result.last_result !== want.last_result) begin
          $display("%0t: last_result mismatch, expected %0b actual %0b",
                   $time, want.last_result, result.last_result);
          errors++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int seq_len;
    int sent;
    int pick;
    logic [SAMPLE_W-1:0] smp;

    rst         <= 1'b1;
    item_valid  <= 1'b0;
    item        <= '0;
    tx_idle_pct = 30;
    rx_idle_pct = 64;
    taps_taken  = 0;
    foreach (tap_line[i]) tap_line[i] = '0;

    // One-sample sequence: every tap is the same byte, result is zero
    add_row(8'hA5, 1'b1, 1'b1, 0);
    // Flat sequence at full scale: zero everywhere, full flush at the end
    for (int i = 0; i < 10; i++) add_row(8'hFF, (i == 9), 1'b1, 0);
    // Short sequence, reflections clamp to the end samples
    add_row(8'h00, 1'b0, 1'b0, 0);
    add_row(8'hFF, 1'b0, 1'b0, 0);
    add_row(8'h80, 1'b1, 1'b0, 0);
    // Plateau of full-scale samples inside zeros: a large positive peak
    for (int i = 0; i < 10; i++)
      add_row((i >= 3 && i <= 5) ? 8'hFF : 8'h00, (i == 9), 1'b0, 0);

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (stim_rows[i])
      send_sample(stim_rows[i].smp, stim_rows[i].eos, stim_rows[i].has_fixed,
                  stim_rows[i].fixed_disp);

    // Random sequences; idle pattern changes by thirds of the run
    sent = 0;
    while (sent < RAND_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 10)      seq_len = $urandom_range(7, 1);
      else if (pick < 85) seq_len = $urandom_range(30, 8);
      else                seq_len = $urandom_range(60, 31);
      if (seq_len > RAND_ITEMS - sent) seq_len = RAND_ITEMS - sent;
      for (int k = 0; k < seq_len; k++) begin
        if (sent < RAND_ITEMS / 3) begin
          tx_idle_pct = 30;
          rx_idle_pct = 64;
        end else if (sent < 2 * RAND_ITEMS / 3) begin
          tx_idle_pct = 64;
          rx_idle_pct = 30;
        end else begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
        pick = $urandom_range(9);
        if (pick == 0)      smp = 8'h00;
        else if (pick == 1) smp = 8'hFF;
        else                smp = $urandom_range(255);
        send_sample(smp, (k == seq_len - 1), 1'b0, 0);
        sent++;
      end
    end
    item_valid <= 1'b0;

    // Drain, then let the pipeline settle
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3 * REACH) @(posedge clk);

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/ldpf_pkg.sv
rtl/ldpf_tap_cell.sv
rtl/ldpf_mirror_cell.sv
rtl/ldpf_window.sv
rtl/local_dispersion_peak_filter_top.sv
tb/tb_top.sv
